FILE: rtl/mexp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared constants, controller states and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package mexp_pkg;

  // Width of every payload and configuration field.
  localparam int FIELD_W = 32;

  // Default datapath width.
  localparam int WORD_WIDTH_DEF = 32;

  // Value of the modulus register after reset.
  localparam logic [FIELD_W-1:0] MODULUS_RESET = 32'd1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_CHECK,
    ST_EXP,
    ST_MUL_ACC,
    ST_MUL_SQ,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;    // capture base and exponent, clear the remainder
    logic red_step;     // one step of the base reduction
    logic acc_one;      // accumulator to one
    logic acc_zero;     // accumulator to zero
    logic mul_start;    // load the modular multiplier operands
    logic mul_sel_acc;  // multiplier operands: accumulator by power (else power squared)
    logic mul_step;     // one shift-and-add step of the multiplier
    logic acc_write;    // accumulator takes the product
    logic pw_write;     // running power takes the product
    logic exp_shift;    // drop the lowest exponent bit
    logic out_load;     // output register takes the accumulator
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic m_zero;       // modulus is zero
    logic pw_zero;      // reduced base is zero
    logic red_last;     // final reduction step
    logic exp_zero;     // no exponent bits left
    logic exp_bit;      // lowest exponent bit
    logic exp_last;     // lowest exponent bit is the last one set
    logic mul_done;     // multiplier operand exhausted
  } status_t;

endpackage
`default_nettype wire

FILE: rtl/mexp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Modular exponentiation controller
// Sequences the base reduction, the square-and-multiply loop and the
// hand-off to the output register.
// ----------------------------------------------------------------------------
module mexp_ctrl
  import mexp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  wire logic    out_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   out_free;

  // The output slot can take a new item when empty or being drained.
  assign out_free = !out_valid || !out_stall;

  // State and output-valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_REDUCE;
      end
      ST_REDUCE: begin
        if (status.red_last) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (status.m_zero || status.pw_zero) state_next = ST_FINISH;
        else state_next = ST_EXP;
      end
      ST_EXP: begin
        if (status.exp_zero) state_next = ST_FINISH;
        else if (status.exp_bit) state_next = ST_MUL_ACC;
        else state_next = ST_MUL_SQ;
      end
      ST_MUL_ACC: begin
        if (status.mul_done) begin
          if (status.exp_last) state_next = ST_EXP;
          else state_next = ST_MUL_SQ;
        end
      end
      ST_MUL_SQ: begin
        if (status.mul_done) state_next = ST_EXP;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Commands and handshake outputs.
  always_comb begin
    cmd            = '0;
    in_stall       = (state != ST_IDLE);
    out_valid_next = out_valid && out_stall;
    case (state)
      ST_IDLE: begin
        cmd.load_item = in_valid;
      end
      ST_REDUCE: begin
        cmd.red_step = 1'b1;
      end
      ST_CHECK: begin
        cmd.acc_zero = status.m_zero || status.pw_zero;
        cmd.acc_one  = !(status.m_zero || status.pw_zero);
      end
      ST_EXP: begin
        cmd.mul_start   = !status.exp_zero;
        cmd.mul_sel_acc = status.exp_bit;
      end
      ST_MUL_ACC: begin
        cmd.mul_step = !status.mul_done;
        if (status.mul_done) begin
          cmd.acc_write = 1'b1;
          // Square next unless this was the top set bit.
          cmd.exp_shift = status.exp_last;
          cmd.mul_start = !status.exp_last;
        end
      end
      ST_MUL_SQ: begin
        cmd.mul_step  = !status.mul_done;
        cmd.pw_write  = status.mul_done;
        cmd.exp_shift = status.mul_done;
      end
      ST_FINISH: begin
        cmd.out_load = out_free;
        if (out_free) out_valid_next = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/mexp_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Modular exponentiation datapath
// Holds the modulus, a restoring base reducer, the accumulator, the running
// power, the exponent shifter and a radix-2 shift-and-add modular multiplier.
// ----------------------------------------------------------------------------
module mexp_dp
  import mexp_pkg::*;
#(
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wr_en,
  input  wire logic [FIELD_W-1:0] cfg_wr_data,
  input  wire logic [FIELD_W-1:0] base_value,
  input  wire logic [FIELD_W-1:0] exponent,
  output logic      [FIELD_W-1:0] power_result,
  input  wire cmd_t               cmd,
  output status_t                 status
);

  localparam int W     = WORD_WIDTH;
  localparam int CNT_W = $clog2(WORD_WIDTH);

  logic [FIELD_W-1:0] modulus;
  logic [W-1:0]       m;
  logic [W-1:0]       dividend;
  logic [W-1:0]       pw;
  logic [W-1:0]       acc;
  logic [W-1:0]       exp_q;
  logic [W-1:0]       ma;
  logic [W-1:0]       mb;
  logic [W-1:0]       macc;
  logic [W-1:0]       out_data;
  logic [CNT_W-1:0]   cnt;

  logic [W:0]   red_trial;
  logic [W-1:0] red_next;
  logic [W:0]   sum_acc;
  logic [W-1:0] macc_next;
  logic [W:0]   sum_dbl;
  logic [W-1:0] ma_next;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MODULUS_RESET;
    end else if (cfg_wr_en) begin
      modulus <= cfg_wr_data;
    end
  end

  assign m = W'(modulus);

  // Restoring reduction step: shift in the next base bit, subtract once.
  always_comb begin
    red_trial = {pw, dividend[W-1]};
    if (red_trial >= {1'b0, m}) red_next = W'(red_trial - {1'b0, m});
    else red_next = red_trial[W-1:0];
  end

  // Modular adds of the multiplier: partial sum and doubled operand.
  always_comb begin
    sum_acc = {1'b0, macc} + {1'b0, ma};
    if (sum_acc >= {1'b0, m}) macc_next = W'(sum_acc - {1'b0, m});
    else macc_next = sum_acc[W-1:0];
    sum_dbl = {ma, 1'b0};
    if (sum_dbl >= {1'b0, m}) ma_next = W'(sum_dbl - {1'b0, m});
    else ma_next = sum_dbl[W-1:0];
  end

  // Reduction counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.load_item) begin
      cnt <= '0;
    end else if (cmd.red_step) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  // Base reducer and running power.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      dividend <= W'(base_value);
      pw       <= '0;
    end else if (cmd.red_step) begin
      dividend <= {dividend[W-2:0], 1'b0};
      pw       <= red_next;
    end else if (cmd.pw_write) begin
      pw <= macc;
    end
  end

  // Exponent shifter.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      exp_q <= W'(exponent);
    end else if (cmd.exp_shift) begin
      exp_q <= {1'b0, exp_q[W-1:1]};
    end
  end

  // Accumulator.
  always_ff @(posedge clk) begin
    if (cmd.acc_zero) begin
      acc <= '0;
    end else if (cmd.acc_one) begin
      acc <= W'(1);
    end else if (cmd.acc_write) begin
      acc <= macc;
    end
  end

  // Shift-and-add modular multiplier, multiplier bits taken from the bottom.
  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      ma   <= cmd.mul_sel_acc ? acc : pw;
      mb   <= pw;
      macc <= '0;
    end else if (cmd.mul_step) begin
      if (mb[0]) macc <= macc_next;
      ma <= ma_next;
      mb <= {1'b0, mb[W-1:1]};
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= acc;
    end
  end

  assign power_result = FIELD_W'(out_data);

  // Status to the controller.
  always_comb begin
    status.m_zero   = (m == '0);
    status.pw_zero  = (pw == '0);
    status.red_last = (cnt == CNT_W'(W - 1));
    status.exp_zero = (exp_q == '0);
    status.exp_bit  = exp_q[0];
    status.exp_last = (exp_q[W-1:1] == '0);
    status.mul_done = (mb == '0);
  end

endmodule
`default_nettype wire

FILE: rtl/modular_exponentiation.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Modular exponentiation
// Computes base_value to the power exponent modulo the configured modulus by
// right-to-left binary square-and-multiply.
//
//   Channel  Signals                                   Direction
//   input    in_valid, in_stall, base_value, exponent  item in
//   output   out_valid, out_stall, power_result        item out
//   config   cfg_wr_en, cfg_wr_data (modulus)          write only
//
// One item is worked at a time. After the base reduction, each exponent bit
// costs a pass through ST_EXP plus up to two modular products in the shared
// shift-and-add multiplier. A zero reduced base or a zero modulus skips the
// exponent loop and gives zero. Reset is synchronous and sets the modulus
// to one. The output register lets a new item enter while a result is still
// stalled.
// ----------------------------------------------------------------------------
module modular_exponentiation
  import mexp_pkg::*;
#(
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wr_en,
  input  wire logic [FIELD_W-1:0] cfg_wr_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [FIELD_W-1:0] base_value,
  input  wire logic [FIELD_W-1:0] exponent,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic      [FIELD_W-1:0] power_result
);

  cmd_t    cmd;
  status_t status;

  // Sequencer.
  mexp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Arithmetic and storage.
  mexp_dp #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .base_value   (base_value),
    .exponent     (exponent),
    .power_result (power_result),
    .cmd          (cmd),
    .status       (status)
  );

endmodule
`default_nettype wire
